>>> sv/sql_script_statement_splitter_defines.svh
// ----------------------------------------------------------------------------
// SQL script statement splitter: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SQL_SCRIPT_STATEMENT_SPLITTER_DEFINES_SVH
`define SQL_SCRIPT_STATEMENT_SPLITTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SQL script statement splitter package
// Character codes, scan modes, register codes and the result beat type.
// ----------------------------------------------------------------------------
package sss_pkg;

  // Parameter defaults.
  localparam int MAX_TERM_LEN_DEF = 4;
  localparam int POS_WIDTH_DEF    = 16;

  // Field and register widths.
  localparam int OFF_W      = 16;
  localparam int LEN_W      = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Result FIFO depth; a character yields at most two results.
  localparam int OFIFO_DEPTH = 4;

  // Register reset values.
  localparam logic [31:0]      DEF_TERM_CHARS = 32'd59;
  localparam logic [LEN_W-1:0] DEF_TERM_LEN   = 3'd1;

  // Register indexes, taken from paddr[2].
  localparam logic REG_TERM_CHARS = 1'b0;
  localparam logic REG_TERM_LEN   = 1'b1;

  // Character codes.
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Scanner modes.
  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_QUOTE  = 4'b0010,
    MODE_LINE   = 4'b0100,
    MODE_BLOCK  = 4'b1000
  } scan_mode_t;

  // One result beat.
  typedef struct packed {
    logic [OFF_W-1:0] stmt_start;
    logic [OFF_W-1:0] stmt_end;
    logic             ended_by_terminator;
    logic             final_statement;
  } result_t;

endpackage

>>> sv/sql_script_statement_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SQL script statement splitter
// Scans script text one character per beat and reports the start and end
// offsets of each statement closed by a configurable terminator or by the
// end of the text.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+--------------------------------
//   in      | input     | in_valid/in_stall  | text_char, text_last
//   out     | output    | out_valid/out_stall| stmt_start, stmt_end, flags
//   cfg     | APB slave | psel/penable/pready| terminator_chars, _length
//
// One character is taken every cycle while in_stall is low; the whole scan
// step is a single pass of logic from the scan state registers into a
// four-entry result FIFO, and a result is shown on out from the FIFO head.
// A character can produce two results, so in_stall rises while fewer than two
// FIFO entries are free; a stalled output therefore backs up into in_stall.
// Reset is synchronous and clears the scan state, FIFO and registers.
// ----------------------------------------------------------------------------
`include "sql_script_statement_splitter_defines.svh"

module sql_script_statement_splitter
  import sss_pkg::*;
#(
  parameter int MAX_TERM_LEN = MAX_TERM_LEN_DEF,
  parameter int POS_WIDTH    = POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Character input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_text_char,
  input  logic                  in_text_last,
  // Statement output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OFF_W-1:0]      out_stmt_start,
  output logic [OFF_W-1:0]      out_stmt_end,
  output logic                  out_ended_by_terminator,
  output logic                  out_final_statement,
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int WIN     = (MAX_TERM_LEN > 2) ? MAX_TERM_LEN : 2;
  localparam int EXT     = 2 * WIN;
  localparam int IDX_W   = $clog2(EXT);
  localparam int CNT_W   = $clog2(WIN + 1);
  localparam int LEN_CAP = (MAX_TERM_LEN < 4) ? MAX_TERM_LEN : 4;
  localparam int FP_W    = $clog2(OFIFO_DEPTH);
  localparam int FC_W    = $clog2(OFIFO_DEPTH + 1);

  // Configuration registers and the terminator in use.
  logic [31:0]          term_chars_r;
  logic [LEN_W-1:0]     term_len_r;
  logic [31:0]          act_chars_r;
  logic [LEN_W-1:0]     act_len_r;

  // Scan state.
  scan_mode_t           mode_r, mode_nxt;
  logic                 star_r, star_nxt;
  logic [7:0]           win_r [WIN];
  logic [7:0]           win_nxt [WIN];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] start_r, start_nxt;

  // Result FIFO.
  result_t              fifo_mem [OFIFO_DEPTH];
  logic [FP_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [FC_W-1:0]      fifo_cnt_r;

  // Scan step working values.
  logic [31:0]          eff_chars;
  logic [LEN_W-1:0]     eff_len;
  logic [LEN_W-1:0]     lat_len;
  logic [63:0]          chars_wide;
  logic [7:0]           tchar [MAX_TERM_LEN];
  logic [7:0]           w_ext [EXT];
  logic [POS_WIDTH-1:0] pos_tab [EXT];
  logic [POS_WIDTH:0]   pos_sum;
  logic [IDX_W-1:0]     c_len;
  logic [IDX_W-1:0]     h;
  logic [IDX_W-1:0]     idx_v;
  logic [7:0]           c0, c1;
  logic                 two_v;
  logic                 stop_v;
  logic                 do_match;
  logic                 full_v;
  logic                 mism_v;
  logic                 matched_v;
  logic [1:0]           n_v;
  result_t              res_v [2];

  logic                 in_acc;
  logic                 out_acc;
  logic                 cfg_wr;

  // Result offsets are the low bits of the position counter.
  function automatic logic [OFF_W-1:0] to_off(input logic [POS_WIDTH-1:0] p);
    logic [31:0] wide;
    wide = 32'(p);
    return wide[OFF_W-1:0];
  endfunction

  assign in_stall = (fifo_cnt_r > FC_W'(OFIFO_DEPTH - 2));
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (fifo_cnt_r != '0);
  assign out_acc  = out_valid && !out_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_TERM_CHARS: prdata = term_chars_r;
      REG_TERM_LEN:   prdata = 32'(term_len_r);
      default:        prdata = '0;
    endcase
  end

  // Terminator length as the registers give it, clamped to the legal range.
  always_comb begin
    lat_len = term_len_r;
    if (lat_len == '0) begin
      lat_len = LEN_W'(1);
    end
    if (int'(lat_len) > LEN_CAP) begin
      lat_len = LEN_W'(LEN_CAP);
    end
  end

  // A fresh terminator is taken only when no character waits for a decision.
  assign eff_chars  = (cnt_r == '0) ? term_chars_r : act_chars_r;
  assign eff_len    = (cnt_r == '0) ? lat_len : act_len_r;
  assign chars_wide = 64'(eff_chars);

  always_comb begin
    for (int i = 0; i < MAX_TERM_LEN; i++) begin
      tchar[i] = chars_wide[8*i +: 8];
    end
  end

  // Waiting characters with the new one appended.
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      if (i < int'(cnt_r)) begin
        w_ext[i] = win_r[i];
      end else if (i == int'(cnt_r)) begin
        w_ext[i] = in_text_char;
      end else begin
        w_ext[i] = 8'h00;
      end
    end
    for (int i = WIN; i < EXT; i++) begin
      w_ext[i] = 8'h00;
    end
  end

  // Saturated position for every head offset the step can reach.
  always_comb begin
    for (int j = 0; j < EXT; j++) begin
      pos_sum    = {1'b0, pos_r} + (POS_WIDTH + 1)'(j);
      pos_tab[j] = pos_sum[POS_WIDTH] ? '1 : pos_sum[POS_WIDTH-1:0];
    end
  end

  // Scan step: walk the window one decision at a time.
  always_comb begin
    c_len     = IDX_W'(cnt_r) + 1'b1;
    h         = '0;
    stop_v    = 1'b0;
    mode_nxt  = mode_r;
    star_nxt  = star_r;
    start_nxt = start_r;
    matched_v = 1'b0;
    n_v       = '0;
    c0        = 8'h00;
    c1        = 8'h00;
    two_v     = 1'b0;
    do_match  = 1'b0;
    full_v    = 1'b0;
    mism_v    = 1'b0;
    idx_v     = '0;
    res_v[0]  = '0;
    res_v[1]  = '0;

    for (int it = 0; it < WIN; it++) begin
      if (!stop_v && (h < c_len)) begin
        c0       = w_ext[h];
        c1       = w_ext[h + 1'b1];
        two_v    = (h + 1'b1) < c_len;
        do_match = 1'b0;
        case (mode_nxt)
          MODE_QUOTE: begin
            if (c0 == CH_QUOTE) begin
              mode_nxt = MODE_NORMAL;
            end
            h = h + 1'b1;
          end
          MODE_LINE: begin
            if (c0 == CH_NL) begin
              mode_nxt = MODE_NORMAL;
            end
            h = h + 1'b1;
          end
          MODE_BLOCK: begin
            if (star_nxt && (c0 == CH_SLASH)) begin
              mode_nxt = MODE_NORMAL;
              star_nxt = 1'b0;
            end else begin
              star_nxt = (c0 == CH_STAR);
            end
            h = h + 1'b1;
          end
          MODE_NORMAL: begin
            if (c0 == CH_QUOTE) begin
              mode_nxt = MODE_QUOTE;
              h = h + 1'b1;
            end else if ((c0 inside {CH_DASH, CH_SLASH}) && !two_v && !in_text_last) begin
              // A lone opener candidate waits for the next character.
              stop_v = 1'b1;
            end else if ((c0 == CH_DASH) && two_v && (c1 == CH_DASH)) begin
              mode_nxt = MODE_LINE;
              h = h + IDX_W'(2);
            end else if ((c0 == CH_SLASH) && two_v && (c1 == CH_STAR)) begin
              mode_nxt = MODE_BLOCK;
              star_nxt = 1'b0;
              h = h + IDX_W'(2);
            end else begin
              do_match = 1'b1;
            end
          end
          default: begin
            mode_nxt = MODE_NORMAL;
          end
        endcase

        if (do_match) begin
          // Compare the terminator against the characters at hand.
          full_v = 1'b1;
          mism_v = 1'b0;
          for (int i = 0; i < MAX_TERM_LEN; i++) begin
            if (i < int'(eff_len)) begin
              idx_v = h + IDX_W'(i);
              if (idx_v < c_len) begin
                if (w_ext[idx_v] != tchar[i]) begin
                  full_v = 1'b0;
                  mism_v = 1'b1;
                end
              end else begin
                full_v = 1'b0;
              end
            end
          end

          if (full_v) begin
            if (n_v == 2'd0) begin
              res_v[0] = '{to_off(start_nxt), to_off(pos_tab[h]), 1'b1, 1'b0};
              n_v = 2'd1;
            end else if (n_v == 2'd1) begin
              res_v[1] = '{to_off(start_nxt), to_off(pos_tab[h]), 1'b1, 1'b0};
              n_v = 2'd2;
            end
            h = h + IDX_W'(eff_len);
            start_nxt = pos_tab[h];
            if (in_text_last && (h == c_len)) begin
              matched_v = 1'b1;
            end
          end else if (mism_v || in_text_last) begin
            // Partial or failed match: restart one character later.
            h = h + 1'b1;
          end else begin
            stop_v = 1'b1;
          end
        end
      end
    end

    // End of text: report the remainder or mark the last terminated statement.
    if (in_text_last) begin
      if (!matched_v || (n_v == 2'd0)) begin
        if (n_v == 2'd0) begin
          res_v[0] = '{to_off(start_nxt), to_off(pos_tab[h]), 1'b0, 1'b1};
          n_v = 2'd1;
        end else if (n_v == 2'd1) begin
          res_v[1] = '{to_off(start_nxt), to_off(pos_tab[h]), 1'b0, 1'b1};
          n_v = 2'd2;
        end
      end else if (n_v == 2'd1) begin
        res_v[0].final_statement = 1'b1;
      end else begin
        res_v[1].final_statement = 1'b1;
      end
    end

    // Undecided characters move to the front of the window.
    for (int i = 0; i < WIN; i++) begin
      win_nxt[i] = w_ext[h + IDX_W'(i)];
    end
    cnt_nxt = CNT_W'(c_len - h);
    pos_nxt = pos_tab[h];

    // The final character returns the scanner to its reset state.
    if (in_text_last) begin
      mode_nxt  = MODE_NORMAL;
      star_nxt  = 1'b0;
      cnt_nxt   = '0;
      pos_nxt   = '0;
      start_nxt = '0;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_chars_r <= DEF_TERM_CHARS;
      term_len_r   <= DEF_TERM_LEN;
      act_chars_r  <= DEF_TERM_CHARS;
      act_len_r    <= DEF_TERM_LEN;
      mode_r       <= MODE_NORMAL;
      star_r       <= 1'b0;
      cnt_r        <= '0;
      pos_r        <= '0;
      start_r      <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      fifo_cnt_r   <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_TERM_CHARS: term_chars_r <= pwdata;
          REG_TERM_LEN:   term_len_r   <= pwdata[LEN_W-1:0];
          default:        term_chars_r <= term_chars_r;
        endcase
      end
      if (in_acc) begin
        act_chars_r <= eff_chars;
        act_len_r   <= eff_len;
        mode_r      <= mode_nxt;
        star_r      <= star_nxt;
        cnt_r       <= cnt_nxt;
        pos_r       <= pos_nxt;
        start_r     <= start_nxt;
        wr_ptr_r    <= wr_ptr_r + FP_W'(n_v);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + (in_acc ? FC_W'(n_v) : FC_W'(0)) - FC_W'(out_acc);
    end
  end

  // Window characters and FIFO payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r <= win_nxt;
      if (n_v != 2'd0) begin
        fifo_mem[wr_ptr_r] <= res_v[0];
      end
      if (n_v == 2'd2) begin
        fifo_mem[wr_ptr_r + 1'b1] <= res_v[1];
      end
    end
  end

  // Output beat from the FIFO head.
  assign out_stmt_start          = fifo_mem[rd_ptr_r].stmt_start;
  assign out_stmt_end            = fifo_mem[rd_ptr_r].stmt_end;
  assign out_ended_by_terminator = fifo_mem[rd_ptr_r].ended_by_terminator;
  assign out_final_statement     = fifo_mem[rd_ptr_r].final_statement;

  // Checks on the scan and result bookkeeping.
  `SSS_ASSERT_NOW(a_fifo_room, in_acc, fifo_cnt_r <= FC_W'(OFIFO_DEPTH - 2), "accepted a beat without FIFO room")
  `SSS_ASSERT_NEXT(a_last_clears, in_acc && in_text_last, (cnt_r == '0) && (pos_r == '0) && (start_r == '0), "scan state not cleared after final character")
  `SSS_ASSERT_NEXT(a_last_reports, in_acc && in_text_last, out_valid, "final character produced no result")
  `SSS_ASSERT_NEXT(a_win_bound, in_acc, cnt_r < CNT_W'(WIN), "lookahead window overfilled")
  `SSS_ASSERT_NOW(a_start_order, cnt_r != '0, start_r <= pos_r, "statement start past scan position")

endmodule
